// ===== src/ppdf_pkg.sv =====
`default_nettype none

package ppdf_pkg;

  localparam int BUFFER_SAMPLES = 512;
  localparam int HALF_AW = $clog2(BUFFER_SAMPLES);
  localparam int ADDR_W = HALF_AW + 1;
  localparam int STORE_DEPTH = 2 * BUFFER_SAMPLES;
  localparam int COUNT_W = $clog2(BUFFER_SAMPLES + 1);

  localparam int SAMPLE_W = 16;
  localparam int DAC_W = 10;
  localparam int FILL_W = 10;
  localparam int PERIOD_W = 32;
  localparam int DAC_SHIFT = 6;
  localparam logic [DAC_W-1:0] DAC_MID = DAC_W'(512);

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  localparam int OB_DEPTH = 4;
  localparam int OB_AW = $clog2(OB_DEPTH);
  localparam int OB_CW = $clog2(OB_DEPTH + 1);
  localparam int OB_LIMIT = OB_DEPTH - 1;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_COMMIT = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_NOP    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_READY = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_WRITE = 2'd1,
    MEM_READ  = 2'd2
  } mem_op_t;

  typedef struct packed {
    mem_op_t             op;
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] sample;
    logic                updated;
    logic                buffer_request;
    logic                pulse;
    status_t             status;
    logic [FILL_W-1:0]   back_fill;
  } cmd_t;

  typedef struct packed {
    logic [DAC_W-1:0]  dac_value;
    logic              dac_updated;
    logic              buffer_request;
    logic              callback_pulse;
    status_t           status;
    logic [FILL_W-1:0] back_fill;
  } result_t;

endpackage

`default_nettype wire

// ===== src/ppdf_front.sv =====
`default_nettype none

module ppdf_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       action,
  input  wire logic [ppdf_pkg::SAMPLE_W-1:0]    sample,
  input  wire logic                             cfg_we,
  input  wire logic [ppdf_pkg::PERIOD_W-1:0]    cfg_wdata,
  output logic                                  push_valid,
  input  wire logic                             push_ready,
  output ppdf_pkg::cmd_t                        push_cmd
);

  logic                             front_select, front_select_next;
  logic [ppdf_pkg::COUNT_W-1:0]     front_length, front_length_next;
  logic [ppdf_pkg::COUNT_W-1:0]     play_position, play_position_next;
  logic [ppdf_pkg::COUNT_W-1:0]     back_count, back_count_next;
  logic                             swap_pending, swap_pending_next;
  logic [ppdf_pkg::PERIOD_W-1:0]    countdown, countdown_next;
  logic [ppdf_pkg::PERIOD_W-1:0]    period;
  logic [ppdf_pkg::PERIOD_W-1:0]    countdown_dec;
  logic                             accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;
  assign countdown_dec = countdown - ppdf_pkg::PERIOD_W'(1);

  always_comb begin
    front_select_next  = front_select;
    front_length_next  = front_length;
    play_position_next = play_position;
    back_count_next    = back_count;
    swap_pending_next  = swap_pending;
    countdown_next     = countdown;
    push_cmd           = '0;
    push_cmd.op        = ppdf_pkg::MEM_NONE;
    push_cmd.status    = ppdf_pkg::STATUS_OK;
    push_cmd.sample    = sample;
    unique case (ppdf_pkg::action_t'(action))
      ppdf_pkg::ACT_LOAD: begin
        if (back_count >= ppdf_pkg::COUNT_W'(ppdf_pkg::BUFFER_SAMPLES)) begin
          push_cmd.status = ppdf_pkg::STATUS_OVERFLOW;
        end else begin
          push_cmd.op     = ppdf_pkg::MEM_WRITE;
          push_cmd.addr   = {~front_select, back_count[ppdf_pkg::HALF_AW-1:0]};
          back_count_next = back_count + ppdf_pkg::COUNT_W'(1);
        end
      end
      ppdf_pkg::ACT_COMMIT: begin
        if (back_count == '0) begin
          push_cmd.status = ppdf_pkg::STATUS_EMPTY;
        end else if (!swap_pending) begin
          push_cmd.status = ppdf_pkg::STATUS_NOT_READY;
        end else begin
          front_select_next  = ~front_select;
          front_length_next  = back_count;
          back_count_next    = '0;
          play_position_next = '0;
          swap_pending_next  = 1'b0;
        end
      end
      ppdf_pkg::ACT_TICK: begin
        if (!swap_pending) begin
          if (play_position < front_length) begin
            push_cmd.op      = ppdf_pkg::MEM_READ;
            push_cmd.addr    = {front_select, play_position[ppdf_pkg::HALF_AW-1:0]};
            push_cmd.updated = 1'b1;
          end
          play_position_next = play_position + ppdf_pkg::COUNT_W'(1);
          if (play_position_next >= front_length) begin
            swap_pending_next = 1'b1;
          end
          if (period != '0) begin
            if (countdown_dec == '0) begin
              push_cmd.pulse = 1'b1;
              countdown_next = period;
            end else begin
              countdown_next = countdown_dec;
            end
          end
        end
      end
      ppdf_pkg::ACT_NOP: begin
      end
      default: begin
      end
    endcase
    push_cmd.buffer_request = swap_pending_next;
    push_cmd.back_fill      = ppdf_pkg::FILL_W'(back_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_select  <= 1'b0;
      front_length  <= '0;
      play_position <= '0;
      back_count    <= '0;
      swap_pending  <= 1'b1;
      countdown     <= '0;
      period        <= '0;
    end else begin
      if (accept) begin
        front_select  <= front_select_next;
        front_length  <= front_length_next;
        play_position <= play_position_next;
        back_count    <= back_count_next;
        swap_pending  <= swap_pending_next;
        countdown     <= countdown_next;
      end
      if (cfg_we) begin
        period    <= cfg_wdata;
        countdown <= cfg_wdata;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ppdf_queue.sv =====
`default_nettype none

module ppdf_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire ppdf_pkg::cmd_t push_cmd,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output ppdf_pkg::cmd_t    pop_cmd
);

  ppdf_pkg::cmd_t                 entries [ppdf_pkg::QUEUE_DEPTH];
  logic [ppdf_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [ppdf_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [ppdf_pkg::QUEUE_CW-1:0]  count;
  logic                           do_push;
  logic                           do_pop;

  assign push_ready = count != ppdf_pkg::QUEUE_CW'(ppdf_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + ppdf_pkg::QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + ppdf_pkg::QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + ppdf_pkg::QUEUE_CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - ppdf_pkg::QUEUE_CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ppdf_back.sv =====
`default_nettype none

module ppdf_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pop_valid,
  output logic                pop_ready,
  input  wire ppdf_pkg::cmd_t pop_cmd,
  output logic                out_valid,
  input  wire logic           out_ready,
  output ppdf_pkg::result_t   result
);

  logic [ppdf_pkg::SAMPLE_W-1:0] store [ppdf_pkg::STORE_DEPTH];

  logic                          a_valid;
  ppdf_pkg::cmd_t                a_cmd;
  logic [ppdf_pkg::SAMPLE_W-1:0] a_rdata;
  logic [ppdf_pkg::DAC_W-1:0]    dac_level;

  ppdf_pkg::result_t             ob [ppdf_pkg::OB_DEPTH];
  logic [ppdf_pkg::OB_AW-1:0]    ob_wr;
  logic [ppdf_pkg::OB_AW-1:0]    ob_rd;
  logic [ppdf_pkg::OB_CW-1:0]    ob_count;
  logic [ppdf_pkg::OB_CW-1:0]    in_flight;

  logic                          do_pop;
  logic                          do_out;
  logic [ppdf_pkg::SAMPLE_W-1:0] biased;
  logic [ppdf_pkg::SAMPLE_W-1:0] shifted;
  logic [ppdf_pkg::DAC_W-1:0]    level;
  ppdf_pkg::result_t             a_result;

  // slots taken in stage a plus the output buffer
  assign in_flight = ob_count + ppdf_pkg::OB_CW'(a_valid);
  assign pop_ready = in_flight < ppdf_pkg::OB_CW'(ppdf_pkg::OB_LIMIT);
  assign do_pop    = pop_valid && pop_ready;
  assign out_valid = ob_count != '0;
  assign do_out    = out_valid && out_ready;
  assign result    = ob[ob_rd];

  // (s >>> 6) + 512 is the top bits of s with the sign bit flipped
  assign biased  = a_rdata ^ {1'b1, {(ppdf_pkg::SAMPLE_W-1){1'b0}}};
  assign shifted = biased >> ppdf_pkg::DAC_SHIFT;
  assign level   = a_cmd.updated ? shifted[ppdf_pkg::DAC_W-1:0] : dac_level;

  always_comb begin
    a_result.dac_value      = level;
    a_result.dac_updated    = a_cmd.updated;
    a_result.buffer_request = a_cmd.buffer_request;
    a_result.callback_pulse = a_cmd.pulse;
    a_result.status         = a_cmd.status;
    a_result.back_fill      = a_cmd.back_fill;
  end

  always_ff @(posedge clk) begin
    if (do_pop && pop_cmd.op == ppdf_pkg::MEM_WRITE) begin
      store[pop_cmd.addr] <= pop_cmd.sample;
    end
    if (do_pop && pop_cmd.op == ppdf_pkg::MEM_READ) begin
      a_rdata <= store[pop_cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) begin
      a_cmd <= pop_cmd;
    end
    if (a_valid) begin
      ob[ob_wr] <= a_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      dac_level <= ppdf_pkg::DAC_MID;
      ob_wr     <= '0;
      ob_rd     <= '0;
      ob_count  <= '0;
    end else begin
      a_valid <= do_pop;
      if (a_valid) begin
        dac_level <= level;
        ob_wr     <= ob_wr + ppdf_pkg::OB_AW'(1);
      end
      if (do_out) begin
        ob_rd <= ob_rd + ppdf_pkg::OB_AW'(1);
      end
      if (a_valid && !do_out) begin
        ob_count <= ob_count + ppdf_pkg::OB_CW'(1);
      end else if (do_out && !a_valid) begin
        ob_count <= ob_count - ppdf_pkg::OB_CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/ping_pong_audio_dac_feeder.sv =====
// ping-pong audio playback into a 10-bit dac
// input channel (in_valid/in_ready, action, sample): action 0 loads a
// signed 16-bit sample into the back buffer, 1 commits the back buffer,
// 2 is a sample tick, 3 does nothing. every item gives exactly one result
// item on the output channel (out_valid/out_ready) in the same order.
// cfg_we/cfg_wdata set callback_period and reload the countdown at once;
// write it only while no item is in flight.
// the front stage classifies an item and updates the buffer counters in
// the cycle it is accepted, then queues a command for the back stage,
// which does the one sample store access and builds the result.
// throughput: one item per cycle while the receiver takes results, set by the single store port.
// an accepted item passes through the command queue, stage a and the output buffer before out_valid.
// reset: both buffers empty, a commit awaited, dac level 512, countdown
// and period cleared; store contents are left as they are.
// when the receiver stalls, up to 3 results wait in the output buffer, then
// the 4-entry command queue fills, and only then in_ready drops.
`default_nettype none

module ping_pong_audio_dac_feeder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    action,
  input  wire logic signed [15:0]            sample,
  input  wire logic                          cfg_we,
  input  wire logic [31:0]                   cfg_wdata,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [9:0]                         dac_value,
  output logic                               dac_updated,
  output logic                               buffer_request,
  output logic                               callback_pulse,
  output logic [1:0]                         status,
  output logic [9:0]                         back_fill
);

  logic              push_valid;
  logic              push_ready;
  ppdf_pkg::cmd_t    push_cmd;
  logic              pop_valid;
  logic              pop_ready;
  ppdf_pkg::cmd_t    pop_cmd;
  ppdf_pkg::result_t result;

  ppdf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .sample     (sample),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  ppdf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  ppdf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign dac_value      = result.dac_value;
  assign dac_updated    = result.dac_updated;
  assign buffer_request = result.buffer_request;
  assign callback_pulse = result.callback_pulse;
  assign status         = result.status;
  assign back_fill      = result.back_fill;

`ifndef SYNTH
  a_updated_ok : assert property (@(posedge clk) disable iff (rst)
    out_valid && dac_updated |-> status == ppdf_pkg::STATUS_OK)
    else $error("played sample with nonzero status");

  a_pulse_plays : assert property (@(posedge clk) disable iff (rst)
    out_valid && callback_pulse |-> dac_updated)
    else $error("callback pulse without a played sample");

  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> back_fill <= 10'(ppdf_pkg::BUFFER_SAMPLES))
    else $error("back buffer fill beyond its size");

  a_overflow_full : assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ppdf_pkg::STATUS_OVERFLOW
      |-> back_fill == 10'(ppdf_pkg::BUFFER_SAMPLES))
    else $error("load dropped while back buffer not full");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
module tb;

  typedef enum logic [1:0] {
    STEP_ITEM,
    STEP_CONFIG,
    STEP_DRAIN
  } step_kind_t;

  typedef struct packed {
    step_kind_t          kind;
    ppdf_pkg::action_t   act;
    logic signed [15:0]  smp;
    logic [31:0]         period;
  } step_t;

  localparam int TAIL_STEPS = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [1:0] action = ppdf_pkg::ACT_NOP;
  logic signed [15:0] sample = '0;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic [9:0] dac_value;
  logic dac_updated;
  logic buffer_request;
  logic callback_pulse;
  logic [1:0] status;
  logic [9:0] back_fill;

  step_t stim_steps[$];
  ppdf_pkg::result_t predicted_results[$];
  int item_total = 0;
  int mismatches = 0;
  int send_gap = 0;
  int stall_gap = 0;

  // playback state mirror
  logic signed [15:0] pcm_mem [2*ppdf_pkg::BUFFER_SAMPLES];
  logic front_half = 1'b0;
  int front_len = 0;
  int play_pos = 0;
  int back_cnt = 0;
  logic swap_wait = 1'b1;
  logic [31:0] cb_count = '0;
  logic [31:0] cb_period = '0;
  logic [9:0] dac_level_q = 10'd512;

  ping_pong_audio_dac_feeder u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .sample         (sample),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .dac_value      (dac_value),
    .dac_updated    (dac_updated),
    .buffer_request (buffer_request),
    .callback_pulse (callback_pulse),
    .status         (status),
    .back_fill      (back_fill)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void predict_playback(ppdf_pkg::action_t act,
                                           logic signed [15:0] smp);
    ppdf_pkg::result_t r;
    r = '0;
    r.status = ppdf_pkg::STATUS_OK;
    case (act)
      ppdf_pkg::ACT_LOAD: begin
        if (back_cnt >= ppdf_pkg::BUFFER_SAMPLES) begin
          r.status = ppdf_pkg::STATUS_OVERFLOW;
        end else begin
          pcm_mem[(front_half ? 0 : ppdf_pkg::BUFFER_SAMPLES) + back_cnt] = smp;
          back_cnt++;
        end
      end
      ppdf_pkg::ACT_COMMIT: begin
        if (back_cnt == 0) begin
          r.status = ppdf_pkg::STATUS_EMPTY;
        end else if (!swap_wait) begin
          r.status = ppdf_pkg::STATUS_NOT_READY;
        end else begin
          front_half = ~front_half;
          front_len = back_cnt;
          back_cnt = 0;
          play_pos = 0;
          swap_wait = 1'b0;
        end
      end
      ppdf_pkg::ACT_TICK: begin
        if (!swap_wait) begin
          if (play_pos < front_len) begin
            dac_level_q = 10'((int'(pcm_mem[(front_half ? ppdf_pkg::BUFFER_SAMPLES : 0)
                                            + play_pos])
                               >>> ppdf_pkg::DAC_SHIFT) + 512);
            r.dac_updated = 1'b1;
          end
          play_pos++;
          if (play_pos >= front_len) swap_wait = 1'b1;
          if (cb_period != 0) begin
            cb_count = cb_count - 32'd1;
            if (cb_count == 0) begin
              r.callback_pulse = 1'b1;
              cb_count = cb_period;
            end
          end
        end
      end
      default: ;
    endcase
    r.dac_value = dac_level_q;
    r.buffer_request = swap_wait;
    r.back_fill = 10'(back_cnt);
    predicted_results.push_back(r);
  endfunction

  function automatic void push_item(ppdf_pkg::action_t a, logic signed [15:0] s);
    step_t st;
    st = '0;
    st.kind = STEP_ITEM;
    st.act = a;
    st.smp = s;
    stim_steps.push_back(st);
    item_total++;
  endfunction

  function automatic void push_ctrl(step_kind_t k, logic [31:0] v);
    step_t st;
    st = '0;
    st.kind = k;
    st.act = ppdf_pkg::ACT_NOP;
    st.period = v;
    stim_steps.push_back(st);
  endfunction

  function automatic void push_noise();
    push_item(ppdf_pkg::action_t'($urandom_range(0, 3)), 16'($urandom));
  endfunction

  // driver
  always @(posedge clk) begin : drive
    logic nv;
    ppdf_pkg::action_t na;
    logic signed [15:0] ns;
    logic nwe;
    logic [31:0] nwd;
    nv = in_valid;
    na = ppdf_pkg::action_t'(action);
    ns = sample;
    nwe = 1'b0;
    nwd = cfg_wdata;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_playback(ppdf_pkg::action_t'(action), sample);
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (stim_steps.size() != 0) begin
          case (stim_steps[0].kind)
            STEP_ITEM: begin
              if (stim_steps.size() > TAIL_STEPS && $urandom_range(0, 23) == 0) begin
                send_gap = $urandom_range(0, 14);
              end else begin
                nv = 1'b1;
                na = stim_steps[0].act;
                ns = stim_steps[0].smp;
                void'(stim_steps.pop_front());
              end
            end
            STEP_CONFIG: begin
              if (predicted_results.size() == 0) begin
                nwe = 1'b1;
                nwd = stim_steps[0].period;
                cb_period = stim_steps[0].period;
                cb_count = stim_steps[0].period;
                void'(stim_steps.pop_front());
              end
            end
            default: begin
              if (predicted_results.size() == 0) void'(stim_steps.pop_front());
            end
          endcase
        end
      end
    end
    in_valid <= nv;
    action <= na;
    sample <= ns;
    cfg_we <= nwe;
    cfg_wdata <= nwd;
  end

  // monitor
  always @(posedge clk) begin : watch
    ppdf_pkg::result_t got;
    ppdf_pkg::result_t want;
    logic nr;
    nr = 1'b1;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got.dac_value = dac_value;
        got.dac_updated = dac_updated;
        got.buffer_request = buffer_request;
        got.callback_pulse = callback_pulse;
        got.status = ppdf_pkg::status_t'(status);
        got.back_fill = back_fill;
        if (predicted_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: result item with nothing expected, dac %0d fill %0d",
                     dac_value, back_fill);
        end else begin
          want = predicted_results.pop_front();
          if (got.dac_value !== want.dac_value || got.dac_updated !== want.dac_updated ||
              got.buffer_request !== want.buffer_request ||
              got.callback_pulse !== want.callback_pulse ||
              got.status !== want.status || got.back_fill !== want.back_fill) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp dac %0d upd %0b req %0b pulse %0b st %0d fill %0d",
                        " / got dac %0d upd %0b req %0b pulse %0b st %0d fill %0d"},
                       want.dac_value, want.dac_updated, want.buffer_request,
                       want.callback_pulse, want.status, want.back_fill,
                       got.dac_value, got.dac_updated, got.buffer_request,
                       got.callback_pulse, got.status, got.back_fill);
          end
        end
      end
      if (stall_gap != 0) begin
        stall_gap--;
        nr = 1'b0;
      end else if (stim_steps.size() > TAIL_STEPS && $urandom_range(0, 15) == 0) begin
        stall_gap = $urandom_range(0, 14);
        nr = 1'b0;
      end
    end
    out_ready <= nr;
  end

  initial begin
    #8000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int n;
    int extra;
    int phase;
    int cfg_round;
    int spins;

    // directed
    push_ctrl(STEP_CONFIG, 32'd1);
    push_item(ppdf_pkg::ACT_COMMIT, 16'sh0000);
    push_item(ppdf_pkg::ACT_TICK, 16'sh0000);
    push_item(ppdf_pkg::ACT_NOP, 16'sh7fff);
    push_item(ppdf_pkg::ACT_LOAD, 16'sh8000);
    push_item(ppdf_pkg::ACT_LOAD, 16'sh7fff);
    push_item(ppdf_pkg::ACT_LOAD, 16'sh0000);
    push_item(ppdf_pkg::ACT_LOAD, 16'shffff);
    push_item(ppdf_pkg::ACT_LOAD, 16'sh0040);
    push_item(ppdf_pkg::ACT_LOAD, 16'sh003f);
    push_item(ppdf_pkg::ACT_COMMIT, 16'sh0000);
    push_item(ppdf_pkg::ACT_COMMIT, 16'sh0000);
    push_item(ppdf_pkg::ACT_LOAD, 16'sh1234);
    push_item(ppdf_pkg::ACT_COMMIT, 16'sh0000);
    for (int i = 0; i < 7; i++) push_item(ppdf_pkg::ACT_TICK, 16'($urandom));
    push_item(ppdf_pkg::ACT_COMMIT, 16'sh0000);
    push_item(ppdf_pkg::ACT_TICK, 16'sh0000);
    push_item(ppdf_pkg::ACT_TICK, 16'sh0000);
    push_item(ppdf_pkg::ACT_NOP, 16'sh8000);
    push_ctrl(STEP_DRAIN, '0);

    // random phases: fill, commit, play out, with noise mixed in
    phase = 0;
    cfg_round = 0;
    while (item_total < 1725) begin
      if (phase % 5 == 1) begin
        case (cfg_round % 7)
          0: push_ctrl(STEP_CONFIG, 32'd0);
          1: push_ctrl(STEP_CONFIG, 32'd3);
          2: push_ctrl(STEP_CONFIG, 32'hffff_ffff);
          3: push_ctrl(STEP_CONFIG, 32'd2);
          4: push_ctrl(STEP_CONFIG, 32'($urandom_range(4, 40)));
          5: push_ctrl(STEP_CONFIG, 32'($urandom));
          default: push_ctrl(STEP_CONFIG, 32'd1);
        endcase
        cfg_round++;
      end
      if (phase == 8) push_ctrl(STEP_DRAIN, '0);
      n = (phase == 3) ? ppdf_pkg::BUFFER_SAMPLES + 3 : $urandom_range(1, 40);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) push_noise();
        push_item(ppdf_pkg::ACT_LOAD, 16'($urandom));
      end
      if ($urandom_range(0, 7) != 0) push_item(ppdf_pkg::ACT_COMMIT, 16'($urandom));
      extra = (phase == 3) ? 2 : $urandom_range(0, 5);
      for (int i = 0; i < n + extra; i++) begin
        if ($urandom_range(0, 9) == 0) push_noise();
        push_item(ppdf_pkg::ACT_TICK, 16'($urandom));
      end
      phase++;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (stim_steps.size() != 0 || in_valid) @(negedge clk);
    spins = 0;
    while (predicted_results.size() != 0 && spins < 5000) begin
      @(negedge clk);
      spins++;
    end
    repeat (10) @(negedge clk);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== ping_pong_audio_dac_feeder.f =====
src/ppdf_pkg.sv
src/ppdf_front.sv
src/ppdf_queue.sv
src/ppdf_back.sv
src/ping_pong_audio_dac_feeder.sv
tb/tb.sv
